[sv/sov_pkg.sv]
// Package with the shared widths, constants and types of the overlap metrics unit.
`timescale 1ns / 1ps
package sov_pkg;

    localparam int COUNT_WIDTH_DEF         = 32;
    localparam int RATIO_FRACTION_BITS_DEF = 16;

    localparam int LOGIT_W     = 16;
    localparam int MASK_W      = 8;
    localparam int CUT_W       = 17;
    localparam int RATIO_W     = 17;
    localparam int COUNT_OUT_W = 32;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 152;

    localparam logic [MASK_W-1:0] MASK_POSITIVE = 8'd128;

    localparam int QUEUE_DEPTH = 4;

    // Classified pixel as it waits between the front and the accumulators.
    typedef struct packed {
        logic last;
        logic truth;
        logic pred;
    } pixel_class_t;

endpackage

[sv/sov_front.sv]
// Front stage: holds the logit cut, classifies each incoming pixel and pushes it to the queue.
`timescale 1ns / 1ps
module sov_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sov_pkg::CUT_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sov_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          queue_full,
    output logic                          push,
    output sov_pkg::pixel_class_t         push_data
);
    import sov_pkg::*;

    logic signed [CUT_W-1:0]   logit_cut_reg;
    logic signed [LOGIT_W-1:0] logit;
    logic        [MASK_W-1:0]  mask_level;
    logic signed [CUT_W-1:0]   logit_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            logit_cut_reg <= '0;
        end else if (cfg_wr_en) begin
            logit_cut_reg <= cfg_wr_data;
        end
    end

    assign logit      = s_tdata[LOGIT_W-1:0];
    assign mask_level = s_tdata[LOGIT_W+MASK_W-1:LOGIT_W];
    assign logit_ext  = CUT_W'(logit);

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        push_data.pred  = logit_ext >= logit_cut_reg;
        push_data.truth = mask_level >= MASK_POSITIVE;
        push_data.last  = s_tlast;
    end

endmodule

[sv/sov_queue.sv]
// Short queue of classified pixels between the front and the accumulators.
`timescale 1ns / 1ps
module sov_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sov_pkg::pixel_class_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output sov_pkg::pixel_class_t pop_data
);
    import sov_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pixel_class_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;

    assign full      = fill_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/sov_accum.sv]
// Back stage: saturating run counters, handing the run totals to the ratio unit at end of run.
`timescale 1ns / 1ps
module sov_accum #(
    parameter int COUNT_WIDTH = sov_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_not_empty,
    input  sov_pkg::pixel_class_t q_data,
    output logic                  pop,
    input  logic                  ratio_idle,
    output logic                  start,
    output logic [COUNT_WIDTH-1:0] overlap_total,
    output logic [COUNT_WIDTH-1:0] joined_total,
    output logic [COUNT_WIDTH:0]   card_total,
    output logic [COUNT_WIDTH-1:0] agree_total,
    output logic [COUNT_WIDTH-1:0] pixel_total
);
    import sov_pkg::*;

    localparam int CW = COUNT_WIDTH;

    logic [CW-1:0] overlap_reg, overlap_next;
    logic [CW-1:0] joined_reg, joined_next;
    logic [CW:0]   card_reg, card_next;
    logic [CW-1:0] agree_reg, agree_next;
    logic [CW-1:0] pixel_reg, pixel_next;

    logic [CW:0]   overlap_sum, joined_sum, agree_sum, pixel_sum;
    logic [CW+1:0] card_sum;
    logic [1:0]    card_inc;

    // A last pixel waits in the queue until the ratio unit can take the run.
    assign pop   = q_not_empty && (!q_data.last || ratio_idle);
    assign start = pop && q_data.last;

    // Each counter sits at or below its all-ones value, so a carry out means saturation.
    always_comb begin
        card_inc    = {1'b0, q_data.pred} + {1'b0, q_data.truth};
        overlap_sum = {1'b0, overlap_reg} + (CW+1)'(q_data.pred && q_data.truth);
        joined_sum  = {1'b0, joined_reg}  + (CW+1)'(q_data.pred || q_data.truth);
        agree_sum   = {1'b0, agree_reg}   + (CW+1)'(q_data.pred == q_data.truth);
        pixel_sum   = {1'b0, pixel_reg}   + (CW+1)'(1);
        card_sum    = {1'b0, card_reg}    + (CW+2)'(card_inc);

        overlap_total = overlap_sum[CW] ? {CW{1'b1}} : overlap_sum[CW-1:0];
        joined_total  = joined_sum[CW]  ? {CW{1'b1}} : joined_sum[CW-1:0];
        agree_total   = agree_sum[CW]   ? {CW{1'b1}} : agree_sum[CW-1:0];
        pixel_total   = pixel_sum[CW]   ? {CW{1'b1}} : pixel_sum[CW-1:0];
        card_total    = card_sum[CW+1]  ? {(CW+1){1'b1}} : card_sum[CW:0];

        overlap_next = overlap_reg;
        joined_next  = joined_reg;
        card_next    = card_reg;
        agree_next   = agree_reg;
        pixel_next   = pixel_reg;
        if (pop) begin
            if (q_data.last) begin
                overlap_next = '0;
                joined_next  = '0;
                card_next    = '0;
                agree_next   = '0;
                pixel_next   = '0;
            end else begin
                overlap_next = overlap_total;
                joined_next  = joined_total;
                card_next    = card_total;
                agree_next   = agree_total;
                pixel_next   = pixel_total;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overlap_reg <= '0;
            joined_reg  <= '0;
            card_reg    <= '0;
            agree_reg   <= '0;
            pixel_reg   <= '0;
        end else begin
            overlap_reg <= overlap_next;
            joined_reg  <= joined_next;
            card_reg    <= card_next;
            agree_reg   <= agree_next;
            pixel_reg   <= pixel_next;
        end
    end

endmodule

[sv/sov_ratio.sv]
// Ratio unit: three restoring dividers stepping one quotient bit per cycle, plus the result register.
`timescale 1ns / 1ps
module sov_ratio #(
    parameter int COUNT_WIDTH         = sov_pkg::COUNT_WIDTH_DEF,
    parameter int RATIO_FRACTION_BITS = sov_pkg::RATIO_FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    output logic                          idle,
    input  logic [COUNT_WIDTH-1:0]        overlap_total,
    input  logic [COUNT_WIDTH-1:0]        joined_total,
    input  logic [COUNT_WIDTH:0]          card_total,
    input  logic [COUNT_WIDTH-1:0]        agree_total,
    input  logic [COUNT_WIDTH-1:0]        pixel_total,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sov_pkg::M_TDATA_W-1:0] m_tdata
);
    import sov_pkg::*;

    localparam int CW    = COUNT_WIDTH;
    localparam int FB    = RATIO_FRACTION_BITS;
    localparam int DW    = CW + 1;
    localparam int STP_W = $clog2(FB + 1);
    localparam int QW    = (FB + 1 > RATIO_W) ? FB + 1 : RATIO_W;
    localparam int XW    = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
    localparam int LANES = 3;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [STP_W-1:0] step_reg, step_next;

    logic [DW-1:0]    rem_reg  [LANES];
    logic [DW-1:0]    den_reg  [LANES];
    logic [FB-1:0]    quo_reg  [LANES];
    logic             one_reg  [LANES];

    logic [DW-1:0]    num_in   [LANES];
    logic [DW-1:0]    den_in   [LANES];
    logic [DW:0]      rem_dbl  [LANES];
    logic [DW:0]      rem_diff [LANES];
    logic             take     [LANES];
    logic [QW-1:0]    q_full   [LANES];
    logic [RATIO_W-1:0] ratio_out [LANES];

    logic [COUNT_OUT_W-1:0] overlap_out_reg, joined_out_reg, total_out_reg;

    function automatic logic [COUNT_OUT_W-1:0] clamp_count(input logic [CW-1:0] c);
        logic [XW-1:0] cx;
        cx = XW'(c);
        if (cx > XW'({COUNT_OUT_W{1'b1}})) begin
            return {COUNT_OUT_W{1'b1}};
        end
        return cx[COUNT_OUT_W-1:0];
    endfunction

    always_comb begin
        num_in[0] = {1'b0, overlap_total};
        den_in[0] = {1'b0, joined_total};
        num_in[1] = {overlap_total, 1'b0};
        den_in[1] = card_total;
        num_in[2] = {1'b0, agree_total};
        den_in[2] = (pixel_total == '0) ? DW'(1) : {1'b0, pixel_total};
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            rem_dbl[i]  = {rem_reg[i], 1'b0};
            take[i]     = rem_dbl[i] >= {1'b0, den_reg[i]};
            rem_diff[i] = rem_dbl[i] - {1'b0, den_reg[i]};
            // A run with an empty denominator, or a numerator at or above it, is 1.0.
            q_full[i]   = one_reg[i] ? (QW'(1) << FB) : QW'(quo_reg[i]);
            ratio_out[i] = (q_full[i] > QW'({RATIO_W{1'b1}})) ? {RATIO_W{1'b1}}
                                                              : q_full[i][RATIO_W-1:0];
        end
    end

    assign idle     = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_DONE;
    assign m_tdata  = {5'd0, total_out_reg, joined_out_reg, overlap_out_reg,
                       ratio_out[2], ratio_out[1], ratio_out[0]};

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STP_W'(FB - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start) begin
            for (int i = 0; i < LANES; i++) begin
                rem_reg[i] <= num_in[i];
                den_reg[i] <= den_in[i];
                quo_reg[i] <= '0;
                one_reg[i] <= (den_in[i] == '0) || (num_in[i] >= den_in[i]);
            end
            overlap_out_reg <= clamp_count(overlap_total);
            joined_out_reg  <= clamp_count(joined_total);
            total_out_reg   <= clamp_count(pixel_total);
        end else if (state_reg == ST_RUN) begin
            for (int i = 0; i < LANES; i++) begin
                rem_reg[i] <= take[i] ? rem_diff[i][DW-1:0] : rem_dbl[i][DW-1:0];
                quo_reg[i] <= {quo_reg[i][FB-2:0], take[i]};
            end
        end
    end

endmodule

[sv/segmentation_overlap_metrics_unit.sv]
// Top level of the segmentation overlap metrics unit: IoU, Dice and pixel accuracy per run.
//
// Input stream: one pixel word per s_ handshake, s_tdata carrying the Q8.8 logit and the
// mask level, s_tlast marking the last pixel of an evaluation run. Pixels are accepted
// one per cycle while the four-entry classification queue has room.
// Output stream: one result word per run, on the m_ channel, after the last pixel.
// The result follows the accepted last pixel once the pixels queued ahead of it are counted
// and the three restoring dividers, which produce one quotient bit per cycle, have run.
// Pixels of the next run keep accumulating while a result is computed or waits; a last
// pixel that arrives before the previous result has been taken is held in the queue,
// and the queue then fills and drops s_tready.
// The result stays on m_tdata, unchanged, until m_tready is seen high.
// cfg_wr_en writes the logit cut at once; write it only while no pixel is in flight.
// After aresetn the counters are zero, the logit cut is zero and no result is pending.
`timescale 1ns / 1ps
module segmentation_overlap_metrics_unit #(
    parameter int COUNT_WIDTH         = sov_pkg::COUNT_WIDTH_DEF,
    parameter int RATIO_FRACTION_BITS = sov_pkg::RATIO_FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sov_pkg::CUT_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // logit[15:0], mask_level[23:16]
    input  logic [sov_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // iou[16:0], dice[33:17], accuracy[50:34], overlap_count[82:51],
    // joined_count[114:83], total_count[146:115], zero fill[151:147]
    output logic [sov_pkg::M_TDATA_W-1:0] m_tdata
);
    import sov_pkg::*;

    logic                   push, queue_full, pop, q_not_empty;
    pixel_class_t           push_data, pop_data;
    logic                   ratio_idle, start;
    logic [COUNT_WIDTH-1:0] overlap_total, joined_total, agree_total, pixel_total;
    logic [COUNT_WIDTH:0]   card_total;

    sov_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    sov_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    sov_accum #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_data        (pop_data),
        .pop           (pop),
        .ratio_idle    (ratio_idle),
        .start         (start),
        .overlap_total (overlap_total),
        .joined_total  (joined_total),
        .card_total    (card_total),
        .agree_total   (agree_total),
        .pixel_total   (pixel_total)
    );

    sov_ratio #(
        .COUNT_WIDTH         (COUNT_WIDTH),
        .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
    ) u_ratio (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start),
        .idle          (ratio_idle),
        .overlap_total (overlap_total),
        .joined_total  (joined_total),
        .card_total    (card_total),
        .agree_total   (agree_total),
        .pixel_total   (pixel_total),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

[bench/sov_metrics_checker.sv]
// Checker for the overlap metrics unit: predicts each run's metrics word and compares it.
`timescale 1ns / 1ps
module sov_metrics_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sov_pkg::CUT_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sov_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sov_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            results_owed
);
    import sov_pkg::*;

    localparam int          FRAC      = RATIO_FRACTION_BITS_DEF;
    localparam logic [32:0] COUNT_TOP = 33'h0_FFFF_FFFF;
    localparam logic [32:0] CARD_TOP  = 33'h1_FFFF_FFFF;
    localparam logic [63:0] RATIO_TOP = 64'h1_FFFF;
    localparam int          MAX_PRINTS = 40;

    typedef struct packed {
        logic [RATIO_W-1:0]     iou;
        logic [RATIO_W-1:0]     dice;
        logic [RATIO_W-1:0]     accuracy;
        logic [COUNT_OUT_W-1:0] overlap;
        logic [COUNT_OUT_W-1:0] joined;
        logic [COUNT_OUT_W-1:0] total;
    } run_metrics_t;

    logic signed [CUT_W-1:0] logit_cut;
    logic [32:0]             overlap_n;
    logic [32:0]             joined_n;
    logic [32:0]             card_n;
    logic [32:0]             agree_n;
    logic [32:0]             pixel_n;
    run_metrics_t            metrics_due[$];
    int                      mismatches = 0;

    function automatic logic [32:0] sat_inc(input logic [32:0] value, input logic [1:0] step,
                                            input logic [32:0] limit);
        logic [33:0] sum;
        sum = {1'b0, value} + 34'(step);
        return (sum > {1'b0, limit}) ? limit : sum[32:0];
    endfunction

    // Truncated num/den in Q1.16; an empty denominator or num >= den reads as one.
    function automatic logic [RATIO_W-1:0] q_ratio(input logic [63:0] num,
                                                   input logic [63:0] den);
        logic [63:0] q;
        if (den == 0 || num >= den)
            q = 64'd1 << FRAC;
        else
            q = (num << FRAC) / den;
        return (q > RATIO_TOP) ? RATIO_TOP[RATIO_W-1:0] : q[RATIO_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        logic signed [LOGIT_W-1:0] logit;
        logic                      pred;
        logic                      truth;
        run_metrics_t              want;
        run_metrics_t              got;
        if (!aresetn) begin
            logit_cut = '0;
            overlap_n = '0;
            joined_n  = '0;
            card_n    = '0;
            agree_n   = '0;
            pixel_n   = '0;
            metrics_due.delete();
        end else begin
            if (cfg_wr_en)
                logit_cut = cfg_wr_data;

            if (s_tvalid && s_tready) begin
                logit = s_tdata[LOGIT_W-1:0];
                truth = s_tdata[LOGIT_W +: MASK_W] >= MASK_POSITIVE;
                pred  = logit >= logit_cut;
                if (pred && truth)
                    overlap_n = sat_inc(overlap_n, 2'd1, COUNT_TOP);
                if (pred || truth)
                    joined_n = sat_inc(joined_n, 2'd1, COUNT_TOP);
                card_n = sat_inc(card_n, {1'b0, pred} + {1'b0, truth}, CARD_TOP);
                if (pred == truth)
                    agree_n = sat_inc(agree_n, 2'd1, COUNT_TOP);
                pixel_n = sat_inc(pixel_n, 2'd1, COUNT_TOP);

                // The last pixel of a run is counted before the metrics are taken.
                if (s_tlast) begin
                    want.iou      = q_ratio(64'(overlap_n), 64'(joined_n));
                    want.dice     = q_ratio(64'({overlap_n, 1'b0}), 64'(card_n));
                    want.accuracy = q_ratio(64'(agree_n),
                                            64'((pixel_n == 0) ? 33'd1 : pixel_n));
                    want.overlap  = overlap_n[COUNT_OUT_W-1:0];
                    want.joined   = joined_n[COUNT_OUT_W-1:0];
                    want.total    = pixel_n[COUNT_OUT_W-1:0];
                    metrics_due.push_back(want);
                    overlap_n = '0;
                    joined_n  = '0;
                    card_n    = '0;
                    agree_n   = '0;
                    pixel_n   = '0;
                end
            end

            if (m_tvalid && m_tready) begin
                got.iou      = m_tdata[0 +: RATIO_W];
                got.dice     = m_tdata[RATIO_W +: RATIO_W];
                got.accuracy = m_tdata[2*RATIO_W +: RATIO_W];
                got.overlap  = m_tdata[3*RATIO_W +: COUNT_OUT_W];
                got.joined   = m_tdata[3*RATIO_W + COUNT_OUT_W +: COUNT_OUT_W];
                got.total    = m_tdata[3*RATIO_W + 2*COUNT_OUT_W +: COUNT_OUT_W];
                if (metrics_due.size() == 0) begin
                    report_mismatch("metrics word with no run pending");
                end else begin
                    want = metrics_due.pop_front();
                    if (got.iou != want.iou)
                        report_mismatch($sformatf("iou %0d, expected %0d",
                                                  got.iou, want.iou));
                    if (got.dice != want.dice)
                        report_mismatch($sformatf("dice %0d, expected %0d",
                                                  got.dice, want.dice));
                    if (got.accuracy != want.accuracy)
                        report_mismatch($sformatf("accuracy %0d, expected %0d",
                                                  got.accuracy, want.accuracy));
                    if (got.overlap != want.overlap)
                        report_mismatch($sformatf("overlap_count %0d, expected %0d",
                                                  got.overlap, want.overlap));
                    if (got.joined != want.joined)
                        report_mismatch($sformatf("joined_count %0d, expected %0d",
                                                  got.joined, want.joined));
                    if (got.total != want.total)
                        report_mismatch($sformatf("total_count %0d, expected %0d",
                                                  got.total, want.total));
                end
            end
        end
        results_owed <= metrics_due.size();
        fail_count   <= mismatches;
    end

endmodule

[bench/tb_segmentation_overlap_metrics_unit.sv]
// Testbench top for the overlap metrics unit: pixel stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module tb_segmentation_overlap_metrics_unit;
    import sov_pkg::*;

    localparam int DRAIN_CYCLES = 32;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASES       = 8;
    localparam int PHASE_PIXELS = 185;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CUT_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int results_owed;
    int ready_hold   = 0;
    int quiet_cycles = 0;
    bit tx_calm      = 1'b0;
    bit rx_calm      = 1'b0;

    always #6 aclk = ~aclk;

    segmentation_overlap_metrics_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    sov_metrics_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // After each metrics word it takes, the receiver may drop tready for a randomly drawn stall; rx_calm keeps it high.
    always @(posedge aclk) begin
        int stall;
        stall = rx_calm ? 0 : int'($urandom_range(0, 3));
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            ready_hold <= stall;
            m_tready   <= (stall == 0);
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= (ready_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [LOGIT_W-1:0] logit, input logic [MASK_W-1:0] mask,
                              input logic last);
        int gap;
        gap = tx_calm ? 0 : int'($urandom_range(0, 3));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mask, logit};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // The extra cycles let pixels that are still queued reach the counters.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_logit_cut(input int value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[CUT_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int              cut;
        int              sent;
        int              run_len;
        int              lo;
        int              hi;
        int              span;
        bit              linked;
        bit              want;
        logic [LOGIT_W-1:0] logit;
        logic [MASK_W-1:0]  mask;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Cut at its reset value of zero: single-pixel runs and an empty union.
        send_pixel(16'h7FFF, 8'hFF, 1'b1);
        send_pixel(16'h8000, 8'h00, 1'b1);
        send_pixel(16'h0000, 8'h80, 1'b0);
        send_pixel(16'hFFFF, 8'h7F, 1'b0);
        send_pixel(16'h0001, 8'h7F, 1'b0);
        send_pixel(16'h8000, 8'h80, 1'b0);
        send_pixel(16'h7FFF, 8'h00, 1'b1);
        // A cut above every logit never predicts positive.
        set_logit_cut(32768);
        send_pixel(16'h7FFF, 8'hFF, 1'b1);
        send_pixel(16'h8000, 8'h00, 1'b1);
        set_logit_cut(-32768);
        send_pixel(16'h8000, 8'h00, 1'b1);
        send_pixel(16'h8000, 8'hFF, 1'b1);
        set_logit_cut(-1);
        send_pixel(16'hFFFF, 8'h80, 1'b0);
        send_pixel(16'hFFFE, 8'h80, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       cut = 32768;
                1:       cut = -32768;
                2:       cut = 32767;
                3:       cut = 0;
                4:       cut = 256;
                default: cut = int'($urandom_range(0, 65536)) - 32768;
            endcase
            set_logit_cut(cut);
            tx_calm <= ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_PIXELS) begin
                run_len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(40, 120))
                                                      : int'($urandom_range(1, 12));
                // Most runs keep the prediction close to the truth so the ratios spread out.
                linked = ($urandom_range(0, 2) != 0);
                for (int k = 0; k < run_len; k++) begin
                    mask = MASK_W'($urandom);
                    if ($urandom_range(0, 5) == 0)
                        mask = MASK_W'($urandom_range(127, 128));
                    if (!linked) begin
                        logit = LOGIT_W'($urandom);
                    end else begin
                        want = (mask >= MASK_POSITIVE) ^ ($urandom_range(0, 7) == 0);
                        if (want) begin
                            lo = cut;
                            hi = 32767;
                        end else begin
                            lo = -32768;
                            hi = cut - 1;
                        end
                        if (lo > hi) begin
                            logit = LOGIT_W'($urandom);
                        end else begin
                            span = hi - lo;
                            if ($urandom_range(0, 1) == 1 && span > 3)
                                span = 3;
                            logit = want ? LOGIT_W'(lo + int'($urandom_range(0, span)))
                                         : LOGIT_W'(hi - int'($urandom_range(0, span)));
                        end
                    end
                    send_pixel(logit, mask, k == run_len - 1);
                end
                sent += run_len;
                if (sent >= PHASE_PIXELS / 2 && sent - run_len < PHASE_PIXELS / 2)
                    wait_for_results();
            end
        end

        wait_for_results();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[segmentation_overlap_metrics_unit.f]
sv/sov_pkg.sv
sv/sov_front.sv
sv/sov_queue.sv
sv/sov_accum.sv
sv/sov_ratio.sv
sv/segmentation_overlap_metrics_unit.sv
bench/sov_metrics_checker.sv
bench/tb_segmentation_overlap_metrics_unit.sv
